>>> hw/rtl/sxb_pkg.sv
// Shared types and constants for the shifted XOR sprite blitter.
package sxb_pkg;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_XOR    = 2'd1,
        OP_FINISH = 2'd2
    } op_kind_t;

    localparam logic RES_READ   = 1'b0;
    localparam logic RES_FINISH = 1'b1;

    typedef struct packed {
        op_kind_t kind;
        logic     has_spill;
        logic     main_ok;
        logic     spill_ok;
        logic     finish;
    } op_ctl_t;

    localparam int OP_DEPTH   = 4;
    localparam int OP_CNT_W   = $clog2(OP_DEPTH + 1);
    localparam int RES_DEPTH  = 4;
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);
    localparam int RES_W      = 9;

endpackage

>>> hw/rtl/sxb_fifo.sv
// Small register FIFO used for the op queue and the result queue.
module sxb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    output logic [WIDTH-1:0]                 rd_data,
    output logic                             is_full,
    output logic                             is_empty,
    output logic [$clog2(DEPTH+1)-1:0]       count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data  = entries_reg[rd_ptr_reg];
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign count    = count_reg;
endmodule

>>> hw/rtl/sxb_front.sv
// Front end: decodes beats, tracks the sprite cursor and issues frame store ops.
module sxb_front #(
    parameter int BYTES_PER_ROW = 80,
    parameter int ROWS          = 400
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             command,
    input  logic [9:0]             start_x,
    input  logic [8:0]             start_y,
    input  logic [6:0]             sprite_width_bytes,
    input  logic [8:0]             sprite_rows,
    input  logic [7:0]             pixel_byte,
    input  logic [14:0]            read_address,
    output logic                   op_push,
    output sxb_pkg::op_ctl_t       op_ctl,
    output logic [((BYTES_PER_ROW*ROWS > 1) ? $clog2(BYTES_PER_ROW*ROWS) : 1)-1:0] op_addr,
    output logic [7:0]             op_main,
    output logic [7:0]             op_spill
);
    import sxb_pkg::*;

    localparam int STORE  = BYTES_PER_ROW * ROWS;
    localparam int ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int CUR_W  = $clog2(1024 * BYTES_PER_ROW + 257);

    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [6:0]       bytes_left_reg, bytes_left_next;
    logic [8:0]       rows_left_reg, rows_left_next;
    logic [2:0]       shift_reg, shift_next;
    logic [6:0]       row_width_reg, row_width_next;

    logic [CUR_W-1:0] start_addr;
    logic [CUR_W-1:0] cur_inc;
    logic [CUR_W-1:0] row_next;
    logic [15:0]      shifted;
    logic [31:0]      rd_ext;
    logic             sprite_empty;

    always_comb
    begin
        start_addr   = CUR_W'(32'(start_y) * 32'(BYTES_PER_ROW) + 32'(start_x[9:3]));
        cur_inc      = cursor_reg + CUR_W'(1);
        row_next     = cur_inc - CUR_W'(row_width_reg) + CUR_W'(BYTES_PER_ROW);
        shifted      = {pixel_byte, 8'h00} >> shift_reg;
        rd_ext       = 32'(read_address);
        sprite_empty = (sprite_width_bytes == '0) || (sprite_rows == '0);

        cursor_next     = cursor_reg;
        bytes_left_next = bytes_left_reg;
        rows_left_next  = rows_left_reg;
        shift_next      = shift_reg;
        row_width_next  = row_width_reg;

        op_push          = 1'b0;
        op_ctl.kind      = OP_XOR;
        op_ctl.has_spill = (shift_reg != '0);
        op_ctl.main_ok   = (cursor_reg < CUR_W'(STORE));
        op_ctl.spill_ok  = (cur_inc < CUR_W'(STORE));
        op_ctl.finish    = 1'b0;
        op_addr          = cursor_reg[ADDR_W-1:0];
        op_main          = shifted[15:8];
        op_spill         = shifted[7:0];

        if (accept)
        begin
            unique case (cmd_t'(command))
                CMD_BEGIN:
                begin
                    cursor_next     = start_addr;
                    shift_next      = start_x[2:0];
                    row_width_next  = sprite_width_bytes;
                    rows_left_next  = sprite_empty ? '0 : sprite_rows;
                    bytes_left_next = sprite_empty ? '0 : sprite_width_bytes;
                    if (sprite_empty)
                    begin
                        op_push     = 1'b1;
                        op_ctl.kind = OP_FINISH;
                    end
                end
                CMD_DATA:
                begin
                    if ((rows_left_reg != '0) && (bytes_left_reg != '0))
                    begin
                        op_push         = 1'b1;
                        cursor_next     = cur_inc;
                        bytes_left_next = bytes_left_reg - 7'd1;
                        if (bytes_left_reg == 7'd1)
                        begin
                            rows_left_next = rows_left_reg - 9'd1;
                            if (rows_left_reg == 9'd1)
                                op_ctl.finish = 1'b1;
                            else
                            begin
                                bytes_left_next = row_width_reg;
                                cursor_next     = row_next;
                            end
                        end
                    end
                end
                CMD_READ:
                begin
                    op_push        = 1'b1;
                    op_ctl.kind    = OP_READ;
                    op_ctl.main_ok = (rd_ext < 32'(STORE));
                    op_addr        = rd_ext[ADDR_W-1:0];
                end
                CMD_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            bytes_left_reg <= '0;
            rows_left_reg  <= '0;
            shift_reg      <= '0;
            row_width_reg  <= '0;
        end
        else
        begin
            cursor_reg     <= cursor_next;
            bytes_left_reg <= bytes_left_next;
            rows_left_reg  <= rows_left_next;
            shift_reg      <= shift_next;
            row_width_reg  <= row_width_next;
        end
    end
endmodule

>>> hw/rtl/sxb_back.sv
// Back end: frame store, clearing sweep and read-modify-write pipeline.
module sxb_back #(
    parameter int BYTES_PER_ROW = 80,
    parameter int ROWS          = 400
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            op_empty,
    input  sxb_pkg::op_ctl_t                op_ctl,
    input  logic [((BYTES_PER_ROW*ROWS > 1) ? $clog2(BYTES_PER_ROW*ROWS) : 1)-1:0] op_addr,
    input  logic [7:0]                      op_main,
    input  logic [7:0]                      op_spill,
    output logic                            op_pop,
    input  logic [sxb_pkg::RES_CNT_W-1:0]   res_count,
    output logic                            res_push,
    output logic                            res_kind,
    output logic [7:0]                      res_data,
    output logic                            clearing
);
    import sxb_pkg::*;

    localparam int STORE  = BYTES_PER_ROW * ROWS;
    localparam int ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;

    logic [7:0] frame_mem [STORE];
    logic [7:0] mem_q;

    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    logic              phase_reg, phase_next;

    logic              s1_we_reg, s1_res_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_val_reg;
    logic              s1_kind_reg;
    logic              s1_read_ok_reg;
    logic              s1_fwd_reg;
    logic [7:0]        s1_fwd_data_reg;

    logic              head_valid, last_access, room, issue;
    logic [ADDR_W-1:0] acc_addr;
    logic [7:0]        acc_val;
    logic              acc_we, acc_res, acc_kind;
    logic [7:0]        old_data, wr_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;

    always_comb
    begin
        head_valid  = !op_empty && !clearing_reg;
        last_access = !((op_ctl.kind == OP_XOR) && op_ctl.has_spill) || phase_reg;
        acc_addr    = phase_reg ? (op_addr + ADDR_W'(1)) : op_addr;
        acc_val     = phase_reg ? op_spill : op_main;
        acc_we      = (op_ctl.kind == OP_XOR) && (phase_reg ? op_ctl.spill_ok : op_ctl.main_ok);
        acc_res     = (op_ctl.kind == OP_READ) || (op_ctl.kind == OP_FINISH)
                      || ((op_ctl.kind == OP_XOR) && op_ctl.finish && last_access);
        acc_kind    = (op_ctl.kind == OP_READ) ? RES_READ : RES_FINISH;
        room        = ((RES_CNT_W + 1)'(res_count) + (RES_CNT_W + 1)'(s1_res_reg))
                      < (RES_CNT_W + 1)'(RES_DEPTH);
        issue       = head_valid && (!acc_res || room);
        op_pop      = issue && last_access;
        phase_next  = issue ? !last_access : phase_reg;

        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + ADDR_W'(1);
            if (clr_idx_reg == ADDR_W'(STORE - 1))
                clearing_next = 1'b0;
        end

        old_data = s1_fwd_reg ? s1_fwd_data_reg : mem_q;
        wr_data  = old_data ^ s1_val_reg;

        mem_we = clearing_reg || s1_we_reg;
        mem_wa = clearing_reg ? clr_idx_reg : s1_addr_reg;
        mem_wd = clearing_reg ? 8'h00 : wr_data;

        res_push = s1_res_reg;
        res_kind = s1_kind_reg;
        res_data = ((s1_kind_reg == RES_READ) && s1_read_ok_reg) ? old_data : 8'h00;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_wa] <= mem_wd;
        mem_q <= frame_mem[acc_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            phase_reg    <= 1'b0;
            s1_we_reg    <= 1'b0;
            s1_res_reg   <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
            phase_reg    <= phase_next;
            s1_we_reg    <= issue && acc_we;
            s1_res_reg   <= issue && acc_res;
        end
    end

    // bypass: a write landing this cycle is not yet visible to the read
    always_ff @(posedge clk)
    begin
        s1_addr_reg     <= acc_addr;
        s1_val_reg      <= acc_val;
        s1_kind_reg     <= acc_kind;
        s1_read_ok_reg  <= op_ctl.main_ok;
        s1_fwd_reg      <= s1_we_reg && (s1_addr_reg == acc_addr);
        s1_fwd_data_reg <= wr_data;
    end

    assign clearing = clearing_reg;
endmodule

>>> hw/rtl/shifted_xor_sprite_blit.sv
// Read path: a read result passes the op queue, frame store read and result queue.
// Throughput: one beat per cycle while full is low, but a shifted data byte needs
// two frame store accesses (read-modify-writes); an aligned byte or a read needs one.
// Reset: frame store is zeroed by a sweep over all BYTES_PER_ROW*ROWS bytes (32000 at
// defaults) after reset; full stays high until it ends.
module shifted_xor_sprite_blit #(
    parameter int BYTES_PER_ROW = 80,
    parameter int ROWS          = 400
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [9:0]  start_x,
    input  logic [8:0]  start_y,
    input  logic [6:0]  sprite_width_bytes,
    input  logic [8:0]  sprite_rows,
    input  logic [7:0]  pixel_byte,
    input  logic [14:0] read_address,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [7:0]  result_data
);
    import sxb_pkg::*;

    localparam int STORE  = BYTES_PER_ROW * ROWS;
    localparam int ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int OP_W   = $bits(op_ctl_t) + ADDR_W + 16;

    logic              accept;
    logic              clearing;

    logic              f_push;
    op_ctl_t           f_ctl;
    logic [ADDR_W-1:0] f_addr;
    logic [7:0]        f_main, f_spill;

    logic [OP_W-1:0]   op_q_data;
    logic              op_q_full, op_q_empty, op_q_pop;
    logic [OP_CNT_W-1:0] op_q_count;
    op_ctl_t           q_ctl;
    logic [ADDR_W-1:0] q_addr;
    logic [7:0]        q_main, q_spill;

    logic              res_push, res_kind;
    logic [7:0]        res_data;
    logic [RES_W-1:0]  res_q_data;
    logic              res_q_full;
    logic [RES_CNT_W-1:0] res_count;

    assign full   = clearing || op_q_full;
    assign accept = push && !full;

    sxb_front #(
        .BYTES_PER_ROW (BYTES_PER_ROW),
        .ROWS          (ROWS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .command            (command),
        .start_x            (start_x),
        .start_y            (start_y),
        .sprite_width_bytes (sprite_width_bytes),
        .sprite_rows        (sprite_rows),
        .pixel_byte         (pixel_byte),
        .read_address       (read_address),
        .op_push            (f_push),
        .op_ctl             (f_ctl),
        .op_addr            (f_addr),
        .op_main            (f_main),
        .op_spill           (f_spill)
    );

    sxb_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_DEPTH)
    ) u_op_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_push),
        .wr_data  ({f_ctl, f_addr, f_main, f_spill}),
        .rd_en    (op_q_pop),
        .rd_data  (op_q_data),
        .is_full  (op_q_full),
        .is_empty (op_q_empty),
        .count    (op_q_count)
    );

    assign {q_ctl, q_addr, q_main, q_spill} = op_q_data;

    sxb_back #(
        .BYTES_PER_ROW (BYTES_PER_ROW),
        .ROWS          (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_q_empty || (op_q_count == '0)),
        .op_ctl    (q_ctl),
        .op_addr   (q_addr),
        .op_main   (q_main),
        .op_spill  (q_spill),
        .op_pop    (op_q_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_kind  (res_kind),
        .res_data  (res_data),
        .clearing  (clearing)
    );

    sxb_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_push),
        .wr_data  ({res_kind, res_data}),
        .rd_en    (pop && !empty),
        .rd_data  (res_q_data),
        .is_full  (res_q_full),
        .is_empty (empty),
        .count    (res_count)
    );

    assign result_kind = res_q_data[RES_W-1] & ~res_q_full | res_q_data[RES_W-1] & res_q_full;
    assign result_data = res_q_data[7:0];
endmodule
